// ===== src/nkdt_pkg.sv =====
// Package for the name-keyed directory table: field widths, stream packing,
// operation and status codes, and default sizes.
// No dependencies.
`timescale 1ns / 1ps

package nkdt_pkg;

  // Default table geometry
  localparam int ENTRIES_DEF    = 16;
  localparam int NAME_CHARS_DEF = 8;

  // Field widths
  localparam int MODE_W   = 2;
  localparam int NAME_W   = 64;
  localparam int SECTOR_W = 10;
  localparam int KIND_W   = 8;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;

  // Stream widths, padded to whole bytes
  localparam int IN_FIELDS_W  = NAME_W + SECTOR_W + KIND_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STATUS_W + SLOT_W + SECTOR_W + KIND_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_PRESENT   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

endpackage

// ===== src/nkdt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module nkdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/name_keyed_directory_table_top.sv =====
// Top level of the name-keyed directory table: request stream, scan engine,
// entry RAM and valid marks. Depends on nkdt_pkg and nkdt_ram.
//
//   Channel  Dir  tdata fields (low bit up)                          tuser
//   in_      in   name_key[63:0] new_sector[73:64] entry_kind[81:74] mode[1:0]
//   out_     out  status[1:0] slot_index[5:2] found_sector[15:6]    -
//                 found_kind[23:16] table_empty[24]
//
// Each accepted request reads every entry of the entry RAM in turn and compares
// it on the registered read data, then applies the update and loads the output
// register. The next request is taken in the cycle after the result is loaded.
// Reset clears the valid marks and the entry count; the RAM is not cleared.
// A stalled result holds the block in the apply step until it is taken.
`timescale 1ns / 1ps

module name_keyed_directory_table_top #(
  parameter int ENTRIES    = nkdt_pkg::ENTRIES_DEF,
  parameter int NAME_CHARS = nkdt_pkg::NAME_CHARS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: name_key, new_sector, entry_kind (from bit 0 up)
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [nkdt_pkg::IN_TDATA_W-1:0] in_tdata,
  // in_tuser: mode
  input  logic [nkdt_pkg::MODE_W-1:0]    in_tuser,
  // out_tdata: status, slot_index, found_sector, found_kind, table_empty
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [nkdt_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import nkdt_pkg::*;

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int KEY_W  = 8 * NAME_CHARS;
  localparam int DATA_W = KIND_W + SECTOR_W + KEY_W;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_t;

  state_t state_r, state_nxt;

  // Request registers
  logic [MODE_W-1:0]   mode_r;
  logic [KEY_W-1:0]    key_r;
  logic [SECTOR_W-1:0] sec_r;
  logic [KIND_W-1:0]   kind_r;

  // Scan registers
  logic [CNT_W-1:0]    rd_cnt_r;
  logic                cmp_v_r;
  logic [IDX_W-1:0]    cmp_idx_r;
  logic                hit_r;
  logic [IDX_W-1:0]    hit_idx_r;
  logic [SECTOR_W-1:0] hit_sec_r;
  logic [KIND_W-1:0]   hit_kind_r;
  logic                free_r;
  logic [IDX_W-1:0]    free_idx_r;

  // Table state in flip-flops
  logic [ENTRIES-1:0]  valid_r;
  logic [CNT_W-1:0]    cnt_r;

  // Output register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // RAM ports
  logic              ram_we;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;
  logic [KEY_W-1:0]    rd_key;
  logic [SECTOR_W-1:0] rd_sec;
  logic [KIND_W-1:0]   rd_kind;

  logic          in_acc;
  logic [NAME_W-1:0] key_in;
  logic [NAME_W-1:0] key_norm;
  logic          entry_hit;
  logic          entry_free;
  logic          out_load;

  logic [STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]    res_idx;
  logic [SECTOR_W-1:0] res_sec;
  logic [KIND_W-1:0]   res_kind;
  logic                do_add;
  logic                do_rem;
  logic [CNT_W-1:0]    cnt_after;
  logic                res_empty;
  logic [IDX_W+SLOT_W-1:0] slot_ext;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign key_in     = in_tdata[NAME_W-1:0];

  // Normal form of the key: characters up to the first zero, cut to NAME_CHARS
  always_comb begin
    logic run;
    run      = 1'b1;
    key_norm = '0;
    for (int i = 0; i < 8; i++) begin
      if (run && (i < NAME_CHARS) && (key_in[8*i +: 8] != 8'd0)) begin
        key_norm[8*i +: 8] = key_in[8*i +: 8];
      end else begin
        run = 1'b0;
      end
    end
  end

  // Entry RAM: key, sector and type
  nkdt_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx_r),
    .wdata (ram_wdata),
    .raddr (rd_cnt_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign ram_wdata = {kind_r, sec_r, key_r};
  assign rd_key    = ram_rdata[KEY_W-1:0];
  assign rd_sec    = ram_rdata[KEY_W +: SECTOR_W];
  assign rd_kind   = ram_rdata[KEY_W+SECTOR_W +: KIND_W];

  // Per-entry compare on the read data; stored keys are in normal form
  assign entry_hit  = cmp_v_r && valid_r[cmp_idx_r] && (rd_key == key_r) && !hit_r;
  assign entry_free = cmp_v_r && !valid_r[cmp_idx_r] && !free_r;

  // Result and update decision
  always_comb begin
    res_status = STAT_NOT_FOUND;
    res_idx    = '0;
    res_sec    = '0;
    res_kind   = '0;
    do_add     = 1'b0;
    do_rem     = 1'b0;
    case (mode_r)
      MODE_LOOKUP: begin
        if (hit_r) begin
          res_status = STAT_OK;
          res_idx    = hit_idx_r;
          res_sec    = hit_sec_r;
          res_kind   = hit_kind_r;
        end
      end
      MODE_ADD: begin
        if (hit_r) begin
          res_status = STAT_PRESENT;
        end else if (free_r) begin
          res_status = STAT_OK;
          res_idx    = free_idx_r;
          do_add     = 1'b1;
        end else begin
          res_status = STAT_FULL;
        end
      end
      MODE_REMOVE: begin
        if (hit_r) begin
          res_status = STAT_OK;
          res_idx    = hit_idx_r;
          do_rem     = 1'b1;
        end
      end
      default: begin
        res_status = STAT_NOT_FOUND;
      end
    endcase
  end

  assign out_load  = (state_r == S_APPLY) && (!out_valid_r || out_tready);
  assign ram_we    = out_load && do_add;
  assign cnt_after = cnt_r + CNT_W'(do_add) - CNT_W'(do_rem);
  assign res_empty = (cnt_after == '0);
  assign slot_ext  = {{SLOT_W{1'b0}}, res_idx};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (cmp_v_r && (cmp_idx_r == LAST_IDX)) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      cmp_v_r     <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      rd_cnt_r    <= '0;
    end else begin
      state_r <= state_nxt;

      // Output register
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      // Start of a request
      if (in_acc) begin
        rd_cnt_r <= '0;
        cmp_v_r  <= 1'b0;
        hit_r    <= 1'b0;
        free_r   <= 1'b0;
      end else if (state_r == S_SCAN) begin
        // Issue one read per cycle, compare on the registered read data
        if (rd_cnt_r != CNT_FULL) begin
          rd_cnt_r <= rd_cnt_r + 1'b1;
          cmp_v_r  <= 1'b1;
        end else begin
          cmp_v_r  <= 1'b0;
        end
        if (entry_hit) hit_r <= 1'b1;
        if (entry_free) free_r <= 1'b1;
      end

      // Table update, once per request
      if (out_load) begin
        cnt_r <= cnt_after;
        if (do_add) valid_r[free_idx_r] <= 1'b1;
        if (do_rem) valid_r[hit_idx_r] <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_tuser;
      key_r  <= key_norm[KEY_W-1:0];
      sec_r  <= in_tdata[NAME_W +: SECTOR_W];
      kind_r <= in_tdata[NAME_W+SECTOR_W +: KIND_W];
    end
    if (state_r == S_SCAN) begin
      cmp_idx_r <= rd_cnt_r[IDX_W-1:0];
    end
    if (entry_hit) begin
      hit_idx_r  <= cmp_idx_r;
      hit_sec_r  <= rd_sec;
      hit_kind_r <= rd_kind;
    end
    if (entry_free) begin
      free_idx_r <= cmp_idx_r;
    end
    if (out_load) begin
      out_data_r <= OUT_TDATA_W'({res_empty, res_kind, res_sec,
                                  slot_ext[SLOT_W-1:0], res_status});
    end
  end

  // Checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("entry count exceeds table size");

  a_cnt_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(cnt_r))
    else $error("entry count disagrees with valid marks");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_data_r[STATUS_W+SLOT_W+SECTOR_W+KIND_W] == (cnt_r == '0)))
    else $error("table_empty does not match entry count");

  a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    entry_hit |-> valid_r[cmp_idx_r])
    else $error("match taken on an invalid entry");

  a_add_free: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !valid_r[free_idx_r])
    else $error("add writes over a valid entry");

endmodule

// ===== dv/testbench.sv =====
// Testbench for name_keyed_directory_table_top: directed and random lookup, add
// and remove requests, checked against an in-bench table predictor.
// Depends on nkdt_pkg and the RTL of the directory table.
`timescale 1ns / 1ps

module testbench;
  import nkdt_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int ITEM_LATENCY = ENTRIES_DEF + 3;
  localparam int KEY_POOL_SIZE = 24;
  localparam int PHASE_ITEMS = 135;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [SECTOR_W-1:0] sector;
    logic [KIND_W-1:0]   kind;
    logic                empty;
  } dir_result_t;

  // Directory predictor plus queue of outstanding results
  class directory_scoreboard;
    bit                  entry_used   [ENTRIES_DEF];
    logic [NAME_W-1:0]   entry_name   [ENTRIES_DEF];
    logic [SECTOR_W-1:0] entry_sector [ENTRIES_DEF];
    logic [KIND_W-1:0]   entry_kind   [ENTRIES_DEF];
    dir_result_t         pending_results[$];
    int unsigned         error_count;

    function new();
      foreach (entry_used[i]) entry_used[i] = 1'b0;
      error_count = 0;
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction

    // Characters up to the first zero, cut to NAME_CHARS, upper bits zero
    function logic [NAME_W-1:0] normalize_name(logic [NAME_W-1:0] key);
      logic [NAME_W-1:0] norm;
      bit stop;
      norm = '0;
      stop = 1'b0;
      for (int c = 0; c < NAME_CHARS_DEF; c++) begin
        if (key[8*c +: 8] == 8'd0) stop = 1'b1;
        if (!stop) norm[8*c +: 8] = key[8*c +: 8];
      end
      return norm;
    endfunction

    // Equal through the first zero character, or equal in every character
    function bit names_match(logic [NAME_W-1:0] a, logic [NAME_W-1:0] b);
      bit stop;
      bit same;
      stop = 1'b0;
      same = 1'b1;
      for (int c = 0; c < NAME_CHARS_DEF; c++) begin
        if (!stop) begin
          if (a[8*c +: 8] != b[8*c +: 8]) begin
            same = 1'b0;
            stop = 1'b1;
          end else if (a[8*c +: 8] == 8'd0) begin
            stop = 1'b1;
          end
        end
      end
      return same;
    endfunction

    function int find_name(logic [NAME_W-1:0] key);
      for (int i = 0; i < ENTRIES_DEF; i++)
        if (entry_used[i] && names_match(entry_name[i], key)) return i;
      return -1;
    endfunction

    function int first_free();
      for (int i = 0; i < ENTRIES_DEF; i++)
        if (!entry_used[i]) return i;
      return -1;
    endfunction

    function bit table_empty();
      foreach (entry_used[i])
        if (entry_used[i]) return 1'b0;
      return 1'b1;
    endfunction

    // Apply an accepted request to the table and queue its result
    function void note_request(logic [MODE_W-1:0] mode, logic [NAME_W-1:0] key,
                               logic [SECTOR_W-1:0] sector, logic [KIND_W-1:0] kind);
      dir_result_t r;
      int hit;
      r = '0;
      r.status = STAT_NOT_FOUND;
      case (mode)
        MODE_LOOKUP: begin
          hit = find_name(key);
          if (hit >= 0) begin
            r.status = STAT_OK;
            r.slot   = hit[SLOT_W-1:0];
            r.sector = entry_sector[hit];
            r.kind   = entry_kind[hit];
          end
        end
        MODE_ADD: begin
          if (find_name(key) >= 0) begin
            r.status = STAT_PRESENT;
          end else begin
            hit = first_free();
            if (hit < 0) begin
              r.status = STAT_FULL;
            end else begin
              entry_used[hit]   = 1'b1;
              entry_name[hit]   = normalize_name(key);
              entry_sector[hit] = sector;
              entry_kind[hit]   = kind;
              r.status = STAT_OK;
              r.slot   = hit[SLOT_W-1:0];
            end
          end
        end
        MODE_REMOVE: begin
          hit = find_name(key);
          if (hit >= 0) begin
            entry_used[hit] = 1'b0;
            r.status = STAT_OK;
            r.slot   = hit[SLOT_W-1:0];
          end
        end
        default: ;
      endcase
      r.empty = table_empty();
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        error_count++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] word);
      dir_result_t got;
      dir_result_t want;
      got.status = word[0 +: STATUS_W];
      got.slot   = word[STATUS_W +: SLOT_W];
      got.sector = word[STATUS_W + SLOT_W +: SECTOR_W];
      got.kind   = word[STATUS_W + SLOT_W + SECTOR_W +: KIND_W];
      got.empty  = word[STATUS_W + SLOT_W + SECTOR_W + KIND_W];
      if (pending_results.size() == 0) begin
        $error("result %h arrived with no request outstanding", word);
        error_count++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", 16'(want.status), 16'(got.status));
      compare_field("slot_index", 16'(want.slot), 16'(got.slot));
      compare_field("found_sector", 16'(want.sector), 16'(got.sector));
      compare_field("found_kind", 16'(want.kind), 16'(got.kind));
      compare_field("table_empty", 16'(want.empty), 16'(got.empty));
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [MODE_W-1:0]      in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  directory_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic [NAME_W-1:0] key_pool [KEY_POOL_SIZE];
  int unsigned       key_len  [KEY_POOL_SIZE];

  name_keyed_directory_table_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop if the run hangs
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Receiver back-pressure, changed at the falling edge
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Drive one request; called and returns at a falling edge
  task automatic send_request(logic [MODE_W-1:0] mode, logic [NAME_W-1:0] key,
                              logic [SECTOR_W-1:0] sector, logic [KIND_W-1:0] kind);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[0 +: NAME_W]                 = key;
    word[NAME_W +: SECTOR_W]          = sector;
    word[NAME_W + SECTOR_W +: KIND_W] = kind;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
    sb.note_request(mode, key, sector, kind);
    @(negedge clk);
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending_count() != 0) @(negedge clk);
  endtask

  // Pool names with random garbage past the terminating zero at times, or a fully random key
  function automatic logic [NAME_W-1:0] pick_key();
    int unsigned idx;
    logic [NAME_W-1:0] k;
    logic [NAME_W-1:0] junk;
    if ($urandom_range(9) == 0) return {$urandom(), $urandom()};
    idx  = $urandom_range(KEY_POOL_SIZE - 1);
    k    = key_pool[idx];
    junk = {$urandom(), $urandom()};
    if (key_len[idx] < 7 && $urandom_range(2) == 0) k = k | (junk << (8 * (key_len[idx] + 1)));
    return k;
  endfunction

  // Random traffic in stretches that lean toward filling or draining the table
  task automatic run_random(int count);
    bit fill_bias;
    int unsigned roll;
    logic [MODE_W-1:0] mode;
    fill_bias = 1'b1;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) fill_bias = $urandom_range(1);
      roll = $urandom_range(99);
      if (fill_bias)
        mode = (roll < 60) ? MODE_ADD : (roll < 80) ? MODE_LOOKUP :
               (roll < 95) ? MODE_REMOVE : MODE_UNUSED;
      else
        mode = (roll < 15) ? MODE_ADD : (roll < 35) ? MODE_LOOKUP :
               (roll < 95) ? MODE_REMOVE : MODE_UNUSED;
      send_request(mode, pick_key(), SECTOR_W'($urandom()), KIND_W'($urandom()));
    end
  endtask

  initial begin
    sb = new();
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = MODE_LOOKUP;
    send_idle_pct  = 18;
    recv_stall_pct = 45;

    // Name pool: entry 0 is the empty name, the rest 1 to 8 nonzero characters
    for (int i = 0; i < KEY_POOL_SIZE; i++) begin
      key_len[i]  = (i == 0) ? 0 : $urandom_range(1, NAME_CHARS_DEF);
      key_pool[i] = '0;
      for (int c = 0; c < key_len[i]; c++) key_pool[i][8*c +: 8] = 8'($urandom_range(1, 255));
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty table, unused mode
    send_request(MODE_LOOKUP, 64'h0000_0000_0000_4241, '0, '0);
    send_request(MODE_REMOVE, 64'h0000_0000_0000_4241, '0, '0);
    send_request(MODE_UNUSED, '0, '0, '0);
    // Empty name, then garbage behind a zero first character hits it
    send_request(MODE_ADD, 64'h0, 10'h3FF, 8'hFF);
    send_request(MODE_ADD, 64'h1234_5678_9ABC_DE00, 10'h001, 8'h01);
    // Full-length all-ones name with zero data
    send_request(MODE_ADD, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
    // Short name with garbage past its terminator is stored trimmed
    send_request(MODE_ADD, 64'hDEAD_BEEF_CA00_4241, 10'h155, 8'hAA);
    send_request(MODE_LOOKUP, 64'h0000_0000_0000_4241, '0, '0);
    send_request(MODE_LOOKUP, 64'h7700_0000_0000_4241, '0, '0);
    send_request(MODE_LOOKUP, 64'h0000_0000_0043_4241, '0, '0);
    send_request(MODE_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 10'h3FF, 8'hFF);
    send_request(MODE_REMOVE, 64'h0, '0, '0);
    send_request(MODE_LOOKUP, 64'h0, '0, '0);
    send_request(MODE_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 10'h3FF, 8'hFF);
    // Fill every free entry, the last add reports a full table
    for (int i = 0; i < 15; i++)
      send_request(MODE_ADD, 64'h0000_0000_004C_4946 | (64'(i + 1) << 24),
                   SECTOR_W'(i * 67), KIND_W'(i * 17));
    drain_results();

    // Three idling patterns, each closed by a full drain
    for (int p = 0; p < 3; p++) begin
      send_idle_pct  = (p == 0) ? 18 : (p == 1) ? 45 : 0;
      recv_stall_pct = (p == 0) ? 45 : (p == 1) ? 18 : 0;
      run_random(PHASE_ITEMS);
      drain_results();
    end

    repeat (2 * ITEM_LATENCY) @(posedge clk);
    if (sb.error_count == 0 && sb.pending_count() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== name_keyed_directory_table_top.f =====
src/nkdt_pkg.sv
src/nkdt_ram.sv
src/name_keyed_directory_table_top.sv
dv/testbench.sv
